@@ src/weso_pkg.sv @@
package weso_pkg;

    localparam int DEF_MAX_DECIMATION = 64;
    localparam int QUEUE_DEPTH        = 2;

    localparam int DELTA_W  = 16;
    localparam int WIN_W    = 24;
    localparam int SPEED_W  = 32;
    localparam int DIST_W   = 48;
    localparam int DEC_W    = 7;
    localparam int GAIN_W   = 32;
    localparam int ALPHA_W  = 17;
    localparam int PROD_W   = 66;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_PULSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MMPS_PER_RPM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ALPHA  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_PULSE  = 3'd4;

    localparam logic [DEC_W-1:0]   RST_DECIMATION    = 7'd4;
    localparam logic [GAIN_W-1:0]  RST_RPM_PER_PULSE = 32'd65536;
    localparam logic [GAIN_W-1:0]  RST_MMPS_PER_RPM  = 32'd223025;
    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA  = 17'd19661;
    localparam logic [GAIN_W-1:0]  RST_MM_PER_PULSE  = 32'd65536;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    localparam logic signed [PROD_W-1:0] P_S32_MAX = 66'sd2147483647;
    localparam logic signed [PROD_W-1:0] P_S32_MIN = -66'sd2147483648;
    localparam logic signed [PROD_W-1:0] P_S48_MAX = 66'sd140737488355327;
    localparam logic signed [PROD_W-1:0] P_S48_MIN = -66'sd140737488355328;
    localparam logic signed [WIN_W:0]    P_S24_MAX = 25'sd8388607;
    localparam logic signed [WIN_W:0]    P_S24_MIN = -25'sd8388608;

    // queue entry between front and back
    typedef struct packed {
        logic                    clr;
        logic signed [WIN_W-1:0] left;
        logic signed [WIN_W-1:0] right;
    } t_cmd;

    // first member is the top bits, so left_window_pulses lands at bit 0
    typedef struct packed {
        logic signed [DIST_W-1:0]  right_distance;
        logic signed [DIST_W-1:0]  left_distance;
        logic signed [SPEED_W-1:0] speed_average;
        logic signed [SPEED_W-1:0] speed_difference;
        logic signed [SPEED_W-1:0] right_speed_filtered;
        logic signed [SPEED_W-1:0] left_speed_filtered;
        logic signed [SPEED_W-1:0] right_rpm;
        logic signed [SPEED_W-1:0] left_rpm;
        logic signed [WIN_W-1:0]   right_window_pulses;
        logic signed [WIN_W-1:0]   left_window_pulses;
    } t_result;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_MUL_RPM,
        OP_RPM,
        OP_ODO,
        OP_MMPS,
        OP_FPROD,
        OP_FILT
    } t_lane_op;

    function automatic logic signed [WIN_W-1:0] sat24(input logic signed [WIN_W:0] v);
        logic signed [WIN_W-1:0] r;
        if (v > P_S24_MAX) begin
            r = P_S24_MAX[WIN_W-1:0];
        end else if (v < P_S24_MIN) begin
            r = P_S24_MIN[WIN_W-1:0];
        end else begin
            r = v[WIN_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SPEED_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > P_S32_MAX) begin
            r = P_S32_MAX[SPEED_W-1:0];
        end else if (v < P_S32_MIN) begin
            r = P_S32_MIN[SPEED_W-1:0];
        end else begin
            r = v[SPEED_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DIST_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
        logic signed [DIST_W-1:0] r;
        if (v > P_S48_MAX) begin
            r = P_S48_MAX[DIST_W-1:0];
        end else if (v < P_S48_MIN) begin
            r = P_S48_MIN[DIST_W-1:0];
        end else begin
            r = v[DIST_W-1:0];
        end
        return r;
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [PROD_W-1:0] rnd8(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        q   = (mag + PROD_W'(128)) >> 8;
        return v[PROD_W-1] ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic signed [PROD_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        q   = (mag + PROD_W'(32768)) >> 16;
        return v[PROD_W-1] ? $signed(-q) : $signed(q);
    endfunction

endpackage

@@ src/weso_front.sv @@
module weso_front #(
    parameter int MAX_DECIMATION = weso_pkg::DEF_MAX_DECIMATION
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_func,
    input  logic signed [weso_pkg::DELTA_W-1:0]   i_left,
    input  logic signed [weso_pkg::DELTA_W-1:0]   i_right,
    input  logic [weso_pkg::DEC_W-1:0]            i_decimation,
    input  logic                                  i_full,
    output logic                                  o_push,
    output weso_pkg::t_cmd                        o_cmd
);
    import weso_pkg::*;

    localparam int CNT_W = $clog2(MAX_DECIMATION + 1);
    localparam int CMP_W = (CNT_W > DEC_W) ? CNT_W : DEC_W;

    logic signed [WIN_W-1:0] r_left_acc, r_right_acc;
    logic [CNT_W-1:0]        r_cnt;

    logic signed [WIN_W-1:0] n_left_acc, n_right_acc;
    logic [CNT_W-1:0]        n_cnt;
    logic [CMP_W-1:0]        dec_ext, dec_eff, cnt_ext;
    logic                    accept, window_end;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        dec_ext = CMP_W'(i_decimation);
        if (dec_ext == '0) begin
            dec_eff = CMP_W'(1);
        end else if (dec_ext > CMP_W'(MAX_DECIMATION)) begin
            dec_eff = CMP_W'(MAX_DECIMATION);
        end else begin
            dec_eff = dec_ext;
        end
    end

    assign n_left_acc  = sat24({r_left_acc[WIN_W-1], r_left_acc}
                             + {{(WIN_W+1-DELTA_W){i_left[DELTA_W-1]}}, i_left});
    assign n_right_acc = sat24({r_right_acc[WIN_W-1], r_right_acc}
                             + {{(WIN_W+1-DELTA_W){i_right[DELTA_W-1]}}, i_right});
    // stored count stays below MAX_DECIMATION, so +1 never wraps
    assign n_cnt       = r_cnt + CNT_W'(1);
    assign cnt_ext     = CMP_W'(n_cnt);
    assign window_end  = cnt_ext >= dec_eff;

    assign o_push    = accept && (i_func || window_end);
    assign o_cmd.clr   = i_func;
    assign o_cmd.left  = n_left_acc;
    assign o_cmd.right = n_right_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_acc  <= '0;
            r_right_acc <= '0;
            r_cnt       <= '0;
        end else if (accept && !i_func) begin
            if (window_end) begin
                r_left_acc  <= '0;
                r_right_acc <= '0;
                r_cnt       <= '0;
            end else begin
                r_left_acc  <= n_left_acc;
                r_right_acc <= n_right_acc;
                r_cnt       <= n_cnt;
            end
        end
    end

endmodule

@@ src/weso_queue.sv @@
module weso_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  weso_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output weso_pkg::t_cmd   o_cmd,
    input  logic             i_pop
);
    import weso_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ src/weso_lane.sv @@
module weso_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  weso_pkg::t_lane_op                    i_op,
    input  logic signed [weso_pkg::WIN_W-1:0]     i_acc,
    input  logic [weso_pkg::GAIN_W-1:0]           i_rpm_per_pulse,
    input  logic [weso_pkg::GAIN_W-1:0]           i_mmps_per_rpm,
    input  logic [weso_pkg::GAIN_W-1:0]           i_mm_per_pulse,
    input  logic [weso_pkg::ALPHA_W-1:0]          i_alpha,
    output logic signed [weso_pkg::WIN_W-1:0]     o_acc,
    output logic signed [weso_pkg::SPEED_W-1:0]   o_rpm,
    output logic signed [weso_pkg::SPEED_W-1:0]   o_filt,
    output logic signed [weso_pkg::DIST_W-1:0]    o_odo
);
    import weso_pkg::*;

    localparam int OPD_W = GAIN_W + 1;

    logic signed [WIN_W-1:0]   r_acc;
    logic signed [SPEED_W-1:0] r_rpm, r_mmps, r_filt;
    logic signed [DIST_W-1:0]  r_odo;
    logic signed [PROD_W-1:0]  r_prod, r_facc;

    logic signed [OPD_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul, odo_sum, filt_sum;
    logic [ALPHA_W-1:0]        alpha_c, alpha_inv;

    assign alpha_c   = (i_alpha > ALPHA_ONE) ? ALPHA_ONE : i_alpha;
    assign alpha_inv = ALPHA_ONE - alpha_c;

    // one shared multiplier; operands follow the sequencer step
    always_comb begin
        unique case (i_op)
            OP_MUL_RPM: begin
                mul_a = OPD_W'(r_acc);
                mul_b = $signed({1'b0, i_rpm_per_pulse});
            end
            OP_RPM: begin
                mul_a = OPD_W'(r_acc);
                mul_b = $signed({1'b0, i_mm_per_pulse});
            end
            OP_ODO: begin
                mul_a = OPD_W'(r_rpm);
                mul_b = $signed({1'b0, i_mmps_per_rpm});
            end
            OP_MMPS: begin
                mul_a = OPD_W'(r_filt);
                mul_b = $signed(OPD_W'(alpha_inv));
            end
            OP_FPROD: begin
                mul_a = OPD_W'(r_mmps);
                mul_b = $signed(OPD_W'(alpha_c));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul      = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign odo_sum  = PROD_W'(r_odo) + rnd8(r_prod);
    assign filt_sum = r_facc + r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mul;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
            r_odo  <= '0;
        end else begin
            unique case (i_op)
                OP_LOAD:  r_acc  <= i_acc;
                OP_CLEAR: r_odo  <= '0;
                OP_RPM:   r_rpm  <= sat32(rnd8(r_prod));
                OP_ODO:   r_odo  <= sat48(odo_sum);
                OP_MMPS:  r_mmps <= sat32(rnd16(r_prod));
                OP_FPROD: r_facc <= r_prod;
                OP_FILT:  r_filt <= sat32(rnd16(filt_sum));
                default: begin
                end
            endcase
        end
    end

    assign o_acc  = r_acc;
    assign o_rpm  = r_rpm;
    assign o_filt = r_filt;
    assign o_odo  = r_odo;

endmodule

@@ src/weso_back.sv @@
module weso_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  weso_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    input  logic [weso_pkg::GAIN_W-1:0]  i_rpm_per_pulse,
    input  logic [weso_pkg::GAIN_W-1:0]  i_mmps_per_rpm,
    input  logic [weso_pkg::GAIN_W-1:0]  i_mm_per_pulse,
    input  logic [weso_pkg::ALPHA_W-1:0] i_alpha,
    output logic                 o_valid,
    input  logic                 i_ready,
    output weso_pkg::t_result    o_result
);
    import weso_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_RPM,
        S_RPM,
        S_ODO,
        S_MMPS,
        S_FPROD,
        S_FILT,
        S_OUT
    } t_state;

    t_state   r_state;
    logic     r_out_valid;
    t_result  r_result;

    t_lane_op lane_op;
    t_result  n_result;
    logic     load_out;
    logic signed [WIN_W-1:0]   l_acc, r_acc;
    logic signed [SPEED_W-1:0] l_rpm, r_rpm, l_filt, r_filt;
    logic signed [DIST_W-1:0]  l_odo, r_odo;
    logic signed [SPEED_W:0]   diff_w, sum_w;

    assign o_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        unique case (r_state)
            S_IDLE:    lane_op = !i_cmd_valid ? OP_NONE : (i_cmd.clr ? OP_CLEAR : OP_LOAD);
            S_MUL_RPM: lane_op = OP_MUL_RPM;
            S_RPM:     lane_op = OP_RPM;
            S_ODO:     lane_op = OP_ODO;
            S_MMPS:    lane_op = OP_MMPS;
            S_FPROD:   lane_op = OP_FPROD;
            S_FILT:    lane_op = OP_FILT;
            default:   lane_op = OP_NONE;
        endcase
    end

    weso_lane u_left (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (lane_op),
        .i_acc           (i_cmd.left),
        .i_rpm_per_pulse (i_rpm_per_pulse),
        .i_mmps_per_rpm  (i_mmps_per_rpm),
        .i_mm_per_pulse  (i_mm_per_pulse),
        .i_alpha         (i_alpha),
        .o_acc           (l_acc),
        .o_rpm           (l_rpm),
        .o_filt          (l_filt),
        .o_odo           (l_odo)
    );

    weso_lane u_right (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (lane_op),
        .i_acc           (i_cmd.right),
        .i_rpm_per_pulse (i_rpm_per_pulse),
        .i_mmps_per_rpm  (i_mmps_per_rpm),
        .i_mm_per_pulse  (i_mm_per_pulse),
        .i_alpha         (i_alpha),
        .o_acc           (r_acc),
        .o_rpm           (r_rpm),
        .o_filt          (r_filt),
        .o_odo           (r_odo)
    );

    assign diff_w = {l_filt[SPEED_W-1], l_filt} - {r_filt[SPEED_W-1], r_filt};
    assign sum_w  = {l_filt[SPEED_W-1], l_filt} + {r_filt[SPEED_W-1], r_filt};

    always_comb begin
        n_result.left_window_pulses   = l_acc;
        n_result.right_window_pulses  = r_acc;
        n_result.left_rpm             = l_rpm;
        n_result.right_rpm            = r_rpm;
        n_result.left_speed_filtered  = l_filt;
        n_result.right_speed_filtered = r_filt;
        n_result.speed_difference     = sat32(PROD_W'(diff_w));
        // arithmetic shift: rounds toward minus infinity
        n_result.speed_average        = sum_w[SPEED_W:1];
        n_result.left_distance        = l_odo;
        n_result.right_distance       = r_odo;
    end

    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_result    <= n_result;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && !i_cmd.clr) begin
                        r_state <= S_MUL_RPM;
                    end
                end
                S_MUL_RPM: r_state <= S_RPM;
                S_RPM:     r_state <= S_ODO;
                S_ODO:     r_state <= S_MMPS;
                S_MMPS:    r_state <= S_FPROD;
                S_FPROD:   r_state <= S_FILT;
                S_FILT:    r_state <= S_OUT;
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default:   r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_start_after_tick_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_RPM) |-> $past(o_pop && !i_cmd.clr))
        else $error("window sequence started without a popped tick");

    a_clear_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.clr) |=> (r_state == S_IDLE))
        else $error("clear command started the window sequence");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || i_ready)) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not loaded when output register was free");
`endif

endmodule

@@ src/wheel_encoder_speed_odometry_unit.sv @@
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tuser: func; tdata: left/right delta
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: one window result
// cfg      in   i_cfg_we                       i_cfg_idx, i_cfg_data
//
// The front takes one item per cycle while the two-entry queue has room.
// A window result takes the back end through a load, six steps on one shared
// multiplier per wheel, then the output load; a clear needs only its load.
// With decimation D only the tick that ends each window and each clear reach the queue.
// Synchronous active-low reset; no clearing pass, ready the cycle after reset.
// A stalled output holds the back end in its output step; the front keeps
// accepting until the queue fills.
module wheel_encoder_speed_odometry_unit #(
    parameter int MAX_DECIMATION = weso_pkg::DEF_MAX_DECIMATION
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // left_delta[15:0], right_delta[31:16]
    input  logic [0:0]  s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_window_pulses, right_window_pulses, left_rpm, right_rpm,
    // left_speed_filtered, right_speed_filtered, speed_difference,
    // speed_average, left_distance, right_distance
    output logic [335:0] m_axis_tdata,
    input  logic                                 i_cfg_we,
    input  logic [weso_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [weso_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import weso_pkg::*;

    logic [DEC_W-1:0]   r_decimation;
    logic [GAIN_W-1:0]  r_rpm_per_pulse, r_mmps_per_rpm, r_mm_per_pulse;
    logic [ALPHA_W-1:0] r_filter_alpha;

    logic    push, full, cmd_valid, pop;
    t_cmd    push_cmd, head_cmd;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimation    <= RST_DECIMATION;
            r_rpm_per_pulse <= RST_RPM_PER_PULSE;
            r_mmps_per_rpm  <= RST_MMPS_PER_RPM;
            r_filter_alpha  <= RST_FILTER_ALPHA;
            r_mm_per_pulse  <= RST_MM_PER_PULSE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DECIMATION:    r_decimation    <= i_cfg_data[DEC_W-1:0];
                REG_RPM_PER_PULSE: r_rpm_per_pulse <= i_cfg_data[GAIN_W-1:0];
                REG_MMPS_PER_RPM:  r_mmps_per_rpm  <= i_cfg_data[GAIN_W-1:0];
                REG_FILTER_ALPHA:  r_filter_alpha  <= i_cfg_data[ALPHA_W-1:0];
                REG_MM_PER_PULSE:  r_mm_per_pulse  <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    weso_front #(
        .MAX_DECIMATION (MAX_DECIMATION)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser[0]),
        .i_left       ($signed(s_axis_tdata[15:0])),
        .i_right      ($signed(s_axis_tdata[31:16])),
        .i_decimation (r_decimation),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    weso_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    weso_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (head_cmd),
        .o_pop           (pop),
        .i_rpm_per_pulse (r_rpm_per_pulse),
        .i_mmps_per_rpm  (r_mmps_per_rpm),
        .i_mm_per_pulse  (r_mm_per_pulse),
        .i_alpha         (r_filter_alpha),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_result        (result)
    );

    assign m_axis_tdata = result;

endmodule

@@ sim/wheel_encoder_speed_odometry_unit_tb.sv @@
module wheel_encoder_speed_odometry_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import weso_pkg::*;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    localparam longint S24_HI = 64'sd8388607;
    localparam longint S24_LO = -64'sd8388608;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;
    localparam longint S48_HI = 64'sd140737488355327;
    localparam longint S48_LO = -64'sd140737488355328;

    localparam int IDLE_PCT     = 18;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS  = 25;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // left_delta[15:0], right_delta[31:16]
    logic [0:0]            s_axis_tuser;   // func[0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [335:0]          m_axis_tdata;   // t_result, left_window_pulses at bit 0
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    wheel_encoder_speed_odometry_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // register shadow
    logic [DEC_W-1:0]   dec_reg   = RST_DECIMATION;
    logic [GAIN_W-1:0]  rpm_gain  = RST_RPM_PER_PULSE;
    logic [GAIN_W-1:0]  mmps_gain = RST_MMPS_PER_RPM;
    logic [ALPHA_W-1:0] alpha_reg = RST_FILTER_ALPHA;
    logic [GAIN_W-1:0]  mm_gain   = RST_MM_PER_PULSE;

    // encoder state shadow
    longint win_left = 0;
    longint win_right = 0;
    int     tick_count = 0;
    longint filt_left = 0;
    longint filt_right = 0;
    longint odo_left = 0;
    longint odo_right = 0;

    t_result pending_windows[$];
    int      mismatches = 0;
    bit      gaps_on = 1'b1;

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // round(v * k / 2^sh), ties away from zero
    function automatic longint scale_round(longint v, longint unsigned k, int sh);
        bit neg;
        longint unsigned mag;
        longint unsigned p;
        neg = v < 0;
        mag = neg ? longint'(-v) : longint'(v);
        p = mag * k;
        p = (p + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint low_pass(longint f, longint s, longint a);
        return clamp_to(scale_round(f * (65536 - a) + s * a, 1, 16), S32_LO, S32_HI);
    endfunction

    function automatic void take_sample(logic signed [DELTA_W-1:0] dl,
                                        logic signed [DELTA_W-1:0] dr);
        int      span;
        longint  a;
        longint  lrpm, rrpm, lmm, rmm;
        t_result res;
        win_left  = clamp_to(win_left + longint'(dl), S24_LO, S24_HI);
        win_right = clamp_to(win_right + longint'(dr), S24_LO, S24_HI);
        tick_count++;
        span = dec_reg == 0 ? 1 : (dec_reg > DEF_MAX_DECIMATION ? DEF_MAX_DECIMATION : dec_reg);
        if (tick_count < span) return;

        lrpm = clamp_to(scale_round(win_left, 64'(rpm_gain), 8), S32_LO, S32_HI);
        rrpm = clamp_to(scale_round(win_right, 64'(rpm_gain), 8), S32_LO, S32_HI);
        lmm  = clamp_to(scale_round(lrpm, 64'(mmps_gain), 16), S32_LO, S32_HI);
        rmm  = clamp_to(scale_round(rrpm, 64'(mmps_gain), 16), S32_LO, S32_HI);
        a = alpha_reg > ALPHA_ONE ? longint'(ALPHA_ONE) : longint'(alpha_reg);
        filt_left  = low_pass(filt_left, lmm, a);
        filt_right = low_pass(filt_right, rmm, a);
        odo_left  = clamp_to(odo_left + scale_round(win_left, 64'(mm_gain), 8),
                             S48_LO, S48_HI);
        odo_right = clamp_to(odo_right + scale_round(win_right, 64'(mm_gain), 8),
                             S48_LO, S48_HI);

        res.left_window_pulses   = WIN_W'(win_left);
        res.right_window_pulses  = WIN_W'(win_right);
        res.left_rpm             = SPEED_W'(lrpm);
        res.right_rpm            = SPEED_W'(rrpm);
        res.left_speed_filtered  = SPEED_W'(filt_left);
        res.right_speed_filtered = SPEED_W'(filt_right);
        res.speed_difference     = SPEED_W'(clamp_to(filt_left - filt_right, S32_LO, S32_HI));
        res.speed_average        = SPEED_W'((filt_left + filt_right) >>> 1);
        res.left_distance        = DIST_W'(odo_left);
        res.right_distance       = DIST_W'(odo_right);
        pending_windows.push_back(res);

        win_left = 0;
        win_right = 0;
        tick_count = 0;
    endfunction

    task automatic send_item(logic func, logic signed [DELTA_W-1:0] dl,
                             logic signed [DELTA_W-1:0] dr);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {dr, dl};
        do @(posedge i_clk); while (!s_axis_tready);
        if (func == FUNC_CLEAR) begin
            odo_left = 0;
            odo_right = 0;
        end else begin
            take_sample(dl, dr);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_DECIMATION:    dec_reg   = data[DEC_W-1:0];
            REG_RPM_PER_PULSE: rpm_gain  = data;
            REG_MMPS_PER_RPM:  mmps_gain = data;
            REG_FILTER_ALPHA:  alpha_reg = data[ALPHA_W-1:0];
            REG_MM_PER_PULSE:  mm_gain   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every window to come out, then let a clear or a partial window settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [DELTA_W-1:0] pick_delta();
        int unsigned roll;
        roll = $urandom_range(7);
        if (roll == 0) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        if (roll < 4) return DELTA_W'(int'($urandom_range(400)) - 200);
        return DELTA_W'($urandom);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        return $urandom_range(1) ? $urandom_range(32'h0004_0000) : $urandom;
    endfunction

    task automatic test_default_window();
        send_item(FUNC_TICK, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_TICK, 16'sh8000, 16'sh7FFF);
        // clear in mid window keeps the window sums
        send_item(FUNC_CLEAR, 16'sh1234, -16'sh1234);
        send_item(FUNC_TICK, 16'sh0000, 16'sh0000);
        send_item(FUNC_TICK, 16'sh0001, -16'sh0001);
        repeat (3) send_item(FUNC_TICK, -16'sh0001, 16'sh0001);
        send_item(FUNC_TICK, 16'sh7FFF, 16'sh7FFF);
        drain();
    endtask

    task automatic test_register_corners();
        write_reg(REG_DECIMATION, '0);          // acts as one tick per window
        write_reg(REG_FILTER_ALPHA, '1);        // clamps to unity weight
        write_reg(REG_RPM_PER_PULSE, '1);
        write_reg(REG_MMPS_PER_RPM, '1);
        write_reg(REG_MM_PER_PULSE, '1);
        for (int i = int'(REG_MM_PER_PULSE) + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), $urandom);
        send_item(FUNC_TICK, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_TICK, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_TICK, 16'sh0000, 16'sh0000);
        send_item(FUNC_CLEAR, 16'sh0000, 16'sh0000);
        send_item(FUNC_TICK, 16'sh00FF, -16'sh0100);
        drain();
        write_reg(REG_FILTER_ALPHA, '0);        // filter holds its value
        write_reg(REG_RPM_PER_PULSE, '0);
        write_reg(REG_MMPS_PER_RPM, '0);
        write_reg(REG_MM_PER_PULSE, '0);
        write_reg(REG_DECIMATION, 32'hFFFF_FF81); // upper bits dropped
        send_item(FUNC_TICK, 16'sh0064, -16'sh0064);
        send_item(FUNC_TICK, 16'sh8000, 16'sh7FFF);
        drain();
    endtask

    task automatic test_odometer_saturation();
        write_reg(REG_DECIMATION, DEF_MAX_DECIMATION);
        write_reg(REG_RPM_PER_PULSE, '1);
        write_reg(REG_MMPS_PER_RPM, '1);
        write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(ALPHA_ONE));
        write_reg(REG_MM_PER_PULSE, '1);
        gaps_on = 1'b0;
        repeat (5 * DEF_MAX_DECIMATION) send_item(FUNC_TICK, 16'sh7FFF, 16'sh8000);
        send_item(FUNC_CLEAR, 16'sh7FFF, 16'sh8000);
        drain();
        gaps_on = 1'b1;
        write_reg(REG_DECIMATION, 1);
        send_item(FUNC_TICK, 16'sh8000, 16'sh7FFF);
        send_item(FUNC_TICK, 16'sh7FFF, 16'sh8000);
        drain();
    endtask

    task automatic test_long_window();
        write_reg(REG_DECIMATION, 127);         // clamps to the maximum
        write_reg(REG_RPM_PER_PULSE, RST_RPM_PER_PULSE);
        write_reg(REG_MMPS_PER_RPM, RST_MMPS_PER_RPM);
        write_reg(REG_FILTER_ALPHA, CFG_DATA_W'(RST_FILTER_ALPHA));
        write_reg(REG_MM_PER_PULSE, RST_MM_PER_PULSE);
        repeat (2 * DEF_MAX_DECIMATION + 2) send_item(FUNC_TICK, pick_delta(), pick_delta());
        drain();
    endtask

    task automatic test_random_windows();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(REG_DECIMATION,
                      $urandom_range(3) != 0 ? $urandom_range(1, 6) : $urandom);
            write_reg(REG_RPM_PER_PULSE, pick_gain());
            write_reg(REG_MMPS_PER_RPM, pick_gain());
            write_reg(REG_FILTER_ALPHA,
                      $urandom_range(3) == 0 ? $urandom : $urandom_range(ALPHA_ONE));
            write_reg(REG_MM_PER_PULSE, pick_gain());
            gaps_on = ph != 2;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 6)
                    send_item(FUNC_CLEAR, DELTA_W'($urandom), DELTA_W'($urandom));
                else
                    send_item(FUNC_TICK, pick_delta(), pick_delta());
            end
            drain();
        end
        gaps_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_windows.size() == 0) begin
                if (mismatches < 10)
                    $display("result item with no window pending: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_windows.pop_front();
                check_field("left_window_pulses", want.left_window_pulses,
                            got.left_window_pulses);
                check_field("right_window_pulses", want.right_window_pulses,
                            got.right_window_pulses);
                check_field("left_rpm", want.left_rpm, got.left_rpm);
                check_field("right_rpm", want.right_rpm, got.right_rpm);
                check_field("left_speed_filtered", want.left_speed_filtered,
                            got.left_speed_filtered);
                check_field("right_speed_filtered", want.right_speed_filtered,
                            got.right_speed_filtered);
                check_field("speed_difference", want.speed_difference, got.speed_difference);
                check_field("speed_average", want.speed_average, got.speed_average);
                check_field("left_distance", want.left_distance, got.left_distance);
                check_field("right_distance", want.right_distance, got.right_distance);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL wheel_encoder_speed_odometry_unit");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_TICK;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_DECIMATION;
        i_cfg_data    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_window();
        test_register_corners();
        test_odometer_saturation();
        test_long_window();
        test_random_windows();

        drain();
        if (mismatches == 0 && pending_windows.size() == 0) begin
            $display("PASS wheel_encoder_speed_odometry_unit");
        end else begin
            $display("FAIL wheel_encoder_speed_odometry_unit");
        end
        $finish;
    end

endmodule
